[rtl/pcr_pkg.sv]
// ============================================================================
// pcr_pkg
// Shared types and constants of the palette color realizer.
// ============================================================================
package pcr_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_WRITE     = 2'd0;
    localparam logic [1:0] OP_REALIZE   = 2'd1;
    localparam logic [1:0] OP_UNREALIZE = 2'd2;

    // palette types
    localparam logic [1:0] PT_INDEXED   = 2'd0;
    localparam logic [1:0] PT_BITFIELDS = 2'd1;
    localparam logic [1:0] PT_BGR       = 2'd2;
    localparam logic [1:0] PT_RGB       = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W        = 3;
    localparam logic [2:0] CFG_PALETTE_TYPE = 3'd0;
    localparam logic [2:0] CFG_ENTRY_COUNT  = 3'd1;
    localparam logic [2:0] CFG_RED_MASK     = 3'd2;
    localparam logic [2:0] CFG_GREEN_MASK   = 3'd3;
    localparam logic [2:0] CFG_BLUE_MASK    = 3'd4;

    localparam int COLOR_W = 32;
    localparam int COUNT_W = 9;

    // reset values of the registers
    localparam logic [1:0]         PALETTE_TYPE_RST = PT_RGB;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST  = 9'd3;
    localparam logic [COLOR_W-1:0] RED_MASK_RST     = 32'h0000_F800;
    localparam logic [COLOR_W-1:0] GREEN_MASK_RST   = 32'h0000_07E0;
    localparam logic [COLOR_W-1:0] BLUE_MASK_RST    = 32'h0000_001F;

    // squared RGB distance: at most 3 * 255^2, fits 18 bits
    localparam int               DIST_W    = 18;
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    // request into the bitfield unit
    typedef struct packed {
        logic go;
        logic unpack;
    } t_bf_req;

endpackage

[rtl/pcr_palette_ram.sv]
// ============================================================================
// pcr_palette_ram
// Palette table: one write port, one read port, registered read data.
// ============================================================================
module pcr_palette_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [pcr_pkg::COLOR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [pcr_pkg::COLOR_W-1:0] o_rdata
);

    logic [pcr_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [pcr_pkg::COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pcr_distance.sv]
// ============================================================================
// pcr_distance
// Registered squared RGB distance between a palette entry and a color.
// ============================================================================
module pcr_distance #(
    parameter int AW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [AW-1:0]               i_idx,
    input  logic [pcr_pkg::COLOR_W-1:0] i_entry,
    input  logic [pcr_pkg::COLOR_W-1:0] i_rgb,
    output logic                        o_valid,
    output logic [AW-1:0]               o_idx,
    output logic [pcr_pkg::DIST_W-1:0]  o_dist
);

    logic [7:0]                 diff [3];
    logic [15:0]                sq   [3];
    logic [pcr_pkg::DIST_W-1:0] n_dist;
    logic                       r_valid;
    logic [AW-1:0]              r_idx;
    logic [pcr_pkg::DIST_W-1:0] r_dist;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = (i_rgb[8*k +: 8] > i_entry[8*k +: 8])
                    ? i_rgb[8*k +: 8] - i_entry[8*k +: 8]
                    : i_entry[8*k +: 8] - i_rgb[8*k +: 8];
            sq[k]   = diff[k] * diff[k];
        end
        n_dist = pcr_pkg::DIST_W'(sq[0]) + pcr_pkg::DIST_W'(sq[1])
               + pcr_pkg::DIST_W'(sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_dist <= n_dist;
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;
    assign o_dist  = r_dist;

endmodule

[rtl/pcr_bitfield.sv]
// ============================================================================
// pcr_bitfield
// Bitfield pack / unpack sequencer, mask analysis then merge per channel mask.
// ============================================================================
module pcr_bitfield (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcr_pkg::t_bf_req            i_req,
    input  logic [pcr_pkg::COLOR_W-1:0] i_value,
    input  logic [pcr_pkg::COLOR_W-1:0] i_red_mask,
    input  logic [pcr_pkg::COLOR_W-1:0] i_green_mask,
    input  logic [pcr_pkg::COLOR_W-1:0] i_blue_mask,
    input  logic [1:0]                  i_mask_count,
    output logic                        o_done,
    output logic [pcr_pkg::COLOR_W-1:0] o_result
);

    // leading zeros, 32 for zero
    function automatic logic [5:0] lzc32(input logic [31:0] m);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                n = 6'(31 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(b[i]);
        end
        return n;
    endfunction

    function automatic logic [5:0] pop32(input logic [31:0] m);
        return 6'(pop8(m[7:0])) + 6'(pop8(m[15:8]))
             + 6'(pop8(m[23:16])) + 6'(pop8(m[31:24]));
    endfunction

    logic                        r_busy;
    logic                        r_phase;   // 0: mask analysis, 1: merge
    logic [1:0]                  r_chan;
    logic [1:0]                  r_count;
    logic                        r_unpack;
    logic [pcr_pkg::COLOR_W-1:0] r_value;
    logic [pcr_pkg::COLOR_W-1:0] r_acc;
    logic [pcr_pkg::COLOR_W-1:0] r_mask;
    logic [5:0]                  r_lz;
    logic [5:0]                  r_pop;
    logic                        r_done;

    logic [pcr_pkg::COLOR_W-1:0] sel_mask;
    logic [7:0]                  chan_byte;
    logic [pcr_pkg::COLOR_W-1:0] col;
    logic [pcr_pkg::COLOR_W-1:0] contrib;

    always_comb begin
        case (r_chan)
            2'd0:    sel_mask = i_red_mask;
            2'd1:    sel_mask = i_green_mask;
            2'd2:    sel_mask = i_blue_mask;
            default: sel_mask = '0;
        endcase
        chan_byte = r_value[8*r_chan +: 8];
        col       = (r_value & r_mask) << r_lz;
        if (r_pop != 6'd32) begin
            col = col | (col >> r_pop);
        end
        if (r_unpack) begin
            contrib = {24'd0, col[31:24]} << {r_chan, 3'b000};
        end else begin
            contrib = ({chan_byte, 24'd0} >> r_lz) & r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.go) begin
                    r_busy  <= 1'b1;
                    r_phase <= 1'b0;
                    r_chan  <= 2'd0;
                end
            end else if (!r_phase) begin
                r_phase <= 1'b1;
            end else begin
                r_phase <= 1'b0;
                if (r_chan == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_chan <= r_chan + 2'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_req.go) begin
                r_value  <= i_value;
                r_unpack <= i_req.unpack;
                r_count  <= i_mask_count;
                r_acc    <= '0;
            end
        end else if (!r_phase) begin
            // channels beyond the mask count act as a zero mask
            r_mask <= (r_chan < r_count) ? sel_mask : '0;
            r_lz   <= lzc32(sel_mask);
            r_pop  <= pop32(sel_mask);
        end else if (r_mask != '0) begin
            r_acc <= r_acc | contrib;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[rtl/palette_color_realizer_core.sv]
// ============================================================================
// palette_color_realizer_core
// Converts colors between 0x00BBGGRR RGB and a device pixel format. A beat
// is taken when start is high and busy low; a result beat is shown on
// o_result_color for exactly one cycle with o_result_valid and cannot be
// held off, so the receiver must take it. Palette writes give no result.
// BGR and RGB conversions, out-of-range unrealize and an empty search answer
// in the cycle after the start beat without raising busy. Indexed unrealize
// takes one palette read; the read data is registered into the result.
// Bitfield pack or unpack takes a 3-channel sequencer with a mask analysis
// and a merge step per channel. Indexed realize streams one palette entry
// per cycle through the memory read port into a registered distance stage
// and searches min(entry_count, PALETTE_DEPTH) entries, fewer on an exact
// match, which ends the search. Palette entries that were never written
// read back unknown. The palette memory needs no clearing pass after reset.
// ============================================================================
module palette_color_realizer_core #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // command channel
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_operation,
    input  logic [7:0]                            i_entry_index,
    input  logic [pcr_pkg::COLOR_W-1:0]           i_value,
    // result channel
    output logic                                  o_result_valid,
    output logic [pcr_pkg::COLOR_W-1:0]           o_result_color,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcr_pkg::COLOR_W-1:0]           i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UNREAD,
        ST_BITF
    } t_state;

    function automatic logic [31:0] swap_red_blue(input logic [31:0] v);
        return {v[31:24], v[7:0], v[15:8], v[23:16]};
    endfunction

    // ---------------------------------------------------------------- config
    logic [1:0]                  r_palette_type;
    logic [pcr_pkg::COUNT_W-1:0] r_entry_count;
    logic [pcr_pkg::COLOR_W-1:0] r_red_mask;
    logic [pcr_pkg::COLOR_W-1:0] r_green_mask;
    logic [pcr_pkg::COLOR_W-1:0] r_blue_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_type <= pcr_pkg::PALETTE_TYPE_RST;
            r_entry_count  <= pcr_pkg::ENTRY_COUNT_RST;
            r_red_mask     <= pcr_pkg::RED_MASK_RST;
            r_green_mask   <= pcr_pkg::GREEN_MASK_RST;
            r_blue_mask    <= pcr_pkg::BLUE_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcr_pkg::CFG_PALETTE_TYPE: r_palette_type <= i_cfg_data[1:0];
                pcr_pkg::CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_data[8:0];
                pcr_pkg::CFG_RED_MASK:     r_red_mask     <= i_cfg_data;
                pcr_pkg::CFG_GREEN_MASK:   r_green_mask   <= i_cfg_data;
                pcr_pkg::CFG_BLUE_MASK:    r_blue_mask    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    t_state                      r_state;
    logic                        r_result_valid;
    logic [pcr_pkg::COLOR_W-1:0] r_result_color;
    logic [CW-1:0]               r_issue_idx;   // next entry to read
    logic [CW-1:0]               r_n;           // entries to search
    logic                        r_hit;         // exact match seen
    logic [pcr_pkg::DIST_W-1:0]  r_best;
    logic [AW-1:0]               r_pick;
    logic [pcr_pkg::COLOR_W-1:0] r_rgb;
    logic                        r_rd_valid;    // search read in flight
    logic [AW-1:0]               r_rd_idx;

    logic                        accept;
    logic [CW-1:0]               n_n;
    logic                        wr_in_range;
    logic                        unr_in_range;
    logic                        issue;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [pcr_pkg::COLOR_W-1:0] ram_rdata;
    logic                        dist_valid;
    logic [AW-1:0]               dist_idx;
    logic [pcr_pkg::DIST_W-1:0]  dist_val;
    logic                        search_done;
    logic [1:0]                  mask_count;
    pcr_pkg::t_bf_req            bf_req;
    logic                        bf_done;
    logic [pcr_pkg::COLOR_W-1:0] bf_result;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // entries searched: min(entry_count, depth)
    assign n_n = (r_entry_count < 9'(PALETTE_DEPTH)) ? CW'(r_entry_count)
                                                     : CW'(PALETTE_DEPTH);
    assign wr_in_range  = ({1'b0, i_entry_index} < 9'(PALETTE_DEPTH));
    assign unr_in_range = (i_value < {23'd0, r_entry_count})
                       && (i_value < 32'(PALETTE_DEPTH));
    assign mask_count   = (r_entry_count < 9'd3) ? r_entry_count[1:0] : 2'd3;

    // a write lands at its own start beat; only search reads run while busy
    assign ram_we = accept && (i_operation == pcr_pkg::OP_WRITE) && wr_in_range;
    assign issue  = (r_state == ST_SEARCH) && !r_hit && (r_issue_idx < r_n);

    always_comb begin
        ram_re    = issue;
        ram_raddr = r_issue_idx[AW-1:0];
        if (accept && (i_operation == pcr_pkg::OP_UNREALIZE)
                && (r_palette_type == pcr_pkg::PT_INDEXED) && unr_in_range) begin
            ram_re    = 1'b1;
            ram_raddr = i_value[AW-1:0];
        end
    end

    always_comb begin
        bf_req.go     = accept && (r_palette_type == pcr_pkg::PT_BITFIELDS)
                     && ((i_operation == pcr_pkg::OP_REALIZE)
                      || (i_operation == pcr_pkg::OP_UNREALIZE));
        bf_req.unpack = (i_operation == pcr_pkg::OP_UNREALIZE);
    end

    // finished once reads stop and the distance pipe has drained
    assign search_done = (r_hit || (r_issue_idx == r_n)) && !r_rd_valid && !dist_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_result_valid <= 1'b0;
            r_rd_valid     <= 1'b0;
            r_hit          <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            r_rd_valid     <= issue;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_operation)
                            pcr_pkg::OP_REALIZE: begin
                                case (r_palette_type)
                                    pcr_pkg::PT_INDEXED: begin
                                        if (n_n == '0) begin
                                            r_result_valid <= 1'b1;
                                            r_result_color <= '0;
                                        end else begin
                                            r_state     <= ST_SEARCH;
                                            r_issue_idx <= '0;
                                            r_n         <= n_n;
                                            r_hit       <= 1'b0;
                                            r_best      <= pcr_pkg::DIST_INIT;
                                            r_pick      <= '0;
                                            r_rgb       <= i_value;
                                        end
                                    end
                                    pcr_pkg::PT_BITFIELDS: r_state <= ST_BITF;
                                    pcr_pkg::PT_BGR: begin
                                        r_result_valid <= 1'b1;
                                        r_result_color <= swap_red_blue(i_value);
                                    end
                                    default: begin
                                        r_result_valid <= 1'b1;
                                        r_result_color <= i_value;
                                    end
                                endcase
                            end
                            pcr_pkg::OP_UNREALIZE: begin
                                case (r_palette_type)
                                    pcr_pkg::PT_INDEXED: begin
                                        if (unr_in_range) begin
                                            r_state <= ST_UNREAD;
                                        end else begin
                                            r_result_valid <= 1'b1;
                                            r_result_color <= '0;
                                        end
                                    end
                                    pcr_pkg::PT_BITFIELDS: r_state <= ST_BITF;
                                    pcr_pkg::PT_BGR: begin
                                        r_result_valid <= 1'b1;
                                        r_result_color <= swap_red_blue(i_value);
                                    end
                                    default: begin
                                        r_result_valid <= 1'b1;
                                        r_result_color <= i_value;
                                    end
                                endcase
                            end
                            default: ;  // write or unused code: no result
                        endcase
                    end
                end
                ST_SEARCH: begin
                    if (issue) begin
                        r_issue_idx <= r_issue_idx + CW'(1);
                    end
                    // later entry wins a tie; first exact match freezes pick
                    if (dist_valid && !r_hit && (dist_val <= r_best)) begin
                        r_best <= dist_val;
                        r_pick <= dist_idx;
                        if (dist_val == '0) begin
                            r_hit <= 1'b1;
                        end
                    end
                    if (search_done) begin
                        r_state        <= ST_IDLE;
                        r_result_valid <= 1'b1;
                        r_result_color <= pcr_pkg::COLOR_W'(r_pick);
                    end
                end
                ST_UNREAD: begin
                    r_state        <= ST_IDLE;
                    r_result_valid <= 1'b1;
                    r_result_color <= ram_rdata;
                end
                ST_BITF: begin
                    if (bf_done) begin
                        r_state        <= ST_IDLE;
                        r_result_valid <= 1'b1;
                        r_result_color <= bf_result;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_issue_idx[AW-1:0];
    end

    // ---------------------------------------------------------------- units
    pcr_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_entry_index[AW-1:0]),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcr_distance #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_entry (ram_rdata),
        .i_rgb   (r_rgb),
        .o_valid (dist_valid),
        .o_idx   (dist_idx),
        .o_dist  (dist_val)
    );

    pcr_bitfield u_bitf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (bf_req),
        .i_value      (i_value),
        .i_red_mask   (r_red_mask),
        .i_green_mask (r_green_mask),
        .i_blue_mask  (r_blue_mask),
        .i_mask_count (mask_count),
        .o_done       (bf_done),
        .o_result     (bf_result)
    );

    assign o_result_valid = r_result_valid;
    assign o_result_color = r_result_color;

    // ---------------------------------------------------------------- checks
    // a palette write never produces a result beat
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == pcr_pkg::OP_WRITE)) |=> !o_result_valid)
        else $error("result beat after palette write");

    // leaving a busy operation always delivers its result
    a_busy_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy dropped without a result beat");

    // search never reads past its entry count
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_issue_idx <= r_n))
        else $error("search read past entry count");

    // distance beats only arrive during a search
    a_dist_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_valid |-> (r_state == ST_SEARCH))
        else $error("distance beat outside search");

endmodule

[test/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for palette_color_realizer_core. A behavioral mirror of
// the palette table and the config registers predicts every result beat;
// directed beats hit the corner cases first, then random phases sweep all
// four palette types under varying config and sender idling.
// ============================================================================
module tb_top;
    import pcr_pkg::*;

    localparam int PALETTE_DEPTH = 256;

    // operation 3 has no meaning: the block must swallow it silently
    localparam logic [1:0] OP_NONE = 2'd3;
    // config index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

    // writes and unused ops give no result beat; this covers the longest
    // such tail (the bitfield sequencer) before a config write
    localparam int SETTLE_CYCLES  = 12;
    // quiet cycles tolerated; enough for a full 256-entry search
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_operation = OP_WRITE;
    logic [7:0]             i_entry_index = '0;
    logic [COLOR_W-1:0]     i_value = '0;
    logic                   o_result_valid;
    logic [COLOR_W-1:0]     o_result_color;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_PALETTE_TYPE;
    logic [COLOR_W-1:0]     i_cfg_data = '0;

    // mirror of the block state
    logic [31:0]        palette_mirror [PALETTE_DEPTH];
    logic [1:0]         cur_type;
    logic [COUNT_W-1:0] cur_count;
    logic [31:0]        cur_mask [3];   // red, green, blue

    // colors still owed by the block, oldest first
    logic [31:0] color_due [$];
    logic [31:0] want;

    int fail_count = 0;
    int checked_count = 0;
    int n_writes = 0;
    int n_realize = 0;
    int n_unrealize = 0;
    int n_dead_ops = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int phase_no = 0;
    int idle_plan [3] = '{0, 50, 15};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    palette_color_realizer_core #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_value        (i_value),
        .o_result_valid (o_result_valid),
        .o_result_color (o_result_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // entries scanned by the indexed search
    function automatic int search_len();
        return (cur_count < PALETTE_DEPTH) ? int'(cur_count) : PALETTE_DEPTH;
    endfunction

    // 32 for a zero mask
    function automatic int lead_zeros(input logic [31:0] m);
        int n;
        int b;
        n = 32;
        for (b = 0; b < 32; b++) begin
            if (m[b]) n = 31 - b;
        end
        return n;
    endfunction

    function automatic logic [31:0] swap_rb(input logic [31:0] v);
        return {v[31:24], v[7:0], v[15:8], v[23:16]};
    endfunction

    // RGB -> device value (or palette index)
    function automatic logic [31:0] realize_color(input logic [31:0] rgb);
        logic [31:0] out;
        int          best;
        int          sq_sum;
        int          d;
        int          i;
        int          k;
        int          n_masks;
        bit          hit;
        out = '0;
        n_masks = (cur_count < 3) ? int'(cur_count) : 3;
        case (cur_type)
            PT_INDEXED: begin
                best = 32'h7FFF_FFFF;
                hit  = 1'b0;
                // ties go to the later entry; an exact match stops the scan
                for (i = 0; i < search_len() && !hit; i++) begin
                    sq_sum = 0;
                    for (k = 0; k < 3; k++) begin
                        d = int'(rgb[8*k +: 8]) - int'(palette_mirror[i][8*k +: 8]);
                        sq_sum += d * d;
                    end
                    if (sq_sum <= best) begin
                        best = sq_sum;
                        out  = 32'(i);
                        hit  = (sq_sum == 0);
                    end
                end
            end
            PT_BITFIELDS: begin
                // channel byte to the top, then down to the top of its mask
                for (k = 0; k < n_masks; k++) begin
                    if (cur_mask[k] != '0)
                        out |= ({rgb[8*k +: 8], 24'd0} >> lead_zeros(cur_mask[k]))
                               & cur_mask[k];
                end
            end
            PT_BGR: out = swap_rb(rgb);
            default: out = rgb;
        endcase
        return out;
    endfunction

    // device value -> RGB
    function automatic logic [31:0] restore_color(input logic [31:0] dev);
        logic [31:0] out;
        logic [31:0] col;
        int          k;
        int          n_masks;
        out = '0;
        n_masks = (cur_count < 3) ? int'(cur_count) : 3;
        case (cur_type)
            PT_INDEXED: begin
                if (dev < cur_count && dev < PALETTE_DEPTH)
                    out = palette_mirror[dev[7:0]];
            end
            PT_BITFIELDS: begin
                // left-justify the field, then replicate its top bits
                for (k = 0; k < n_masks; k++) begin
                    if (cur_mask[k] != '0) begin
                        col = (dev & cur_mask[k]) << lead_zeros(cur_mask[k]);
                        if ($countones(cur_mask[k]) < 32)
                            col = col | (col >> $countones(cur_mask[k]));
                        out[8*k +: 8] = col[31:24];
                    end
                end
            end
            PT_BGR: out = swap_rb(dev);
            default: out = dev;
        endcase
        return out;
    endfunction

    // ------------------------------------------------------------------
    // Random value sources
    // ------------------------------------------------------------------

    // half the time channels come from a coarse grid so distance ties happen
    function automatic logic [31:0] pick_color();
        logic [31:0] c;
        int          k;
        c = $urandom();
        if ($urandom_range(1) == 1) begin
            for (k = 0; k < 3; k++)
                c[8*k +: 8] = ($urandom_range(4) == 4) ? 8'hFF
                                                      : 8'(8'h40 * $urandom_range(3));
        end
        return c;
    endfunction

    // contiguous fields half the time, plus empty, full and scattered masks
    function automatic logic [31:0] pick_mask();
        logic [63:0] run;
        int          w;
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom();
            default: begin
                w   = $urandom_range(1, 16);
                run = (64'd1 << w) - 64'd1;
                return run[31:0] << $urandom_range(32 - w);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One command beat. Returns at the edge that took it, with the mirror
    // updated and the owed color queued.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] idx,
                             input logic [31:0] val);
        start         <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_value       <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (op)
            OP_WRITE: begin
                palette_mirror[idx] = val;
                n_writes++;
            end
            OP_REALIZE: begin
                color_due.push_back(realize_color(val));
                n_realize++;
            end
            OP_UNREALIZE: begin
                color_due.push_back(restore_color(val));
                n_unrealize++;
            end
            default: n_dead_ops++;
        endcase
    endtask

    // Sender gap after a beat: random idling, or now and then a full
    // hold-off until every owed color has come back.
    task automatic pace();
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end else if ($urandom_range(99) < 2) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (color_due.size() != 0) @(posedge i_clk);
        end
    endtask

    // Quiesce: no command, nothing owed, silent tail done, busy low.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (color_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Leaves i_cfg_we high so writes can go back to back; caller drops it.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PALETTE_TYPE: cur_type    = data[1:0];
            CFG_ENTRY_COUNT:  cur_count   = data[COUNT_W-1:0];
            CFG_RED_MASK:     cur_mask[0] = data;
            CFG_GREEN_MASK:   cur_mask[1] = data;
            CFG_BLUE_MASK:    cur_mask[2] = data;
            default: ;
        endcase
    endtask

    // New random phase: all five registers, junk above the narrow fields,
    // and the next sender idling level.
    task automatic load_config(input logic [1:0] ptype, input logic [COUNT_W-1:0] count);
        logic [31:0] junk;
        drain();
        junk = $urandom();
        cfg_write(CFG_PALETTE_TYPE, {junk[31:2], ptype});
        cfg_write(CFG_ENTRY_COUNT, {junk[31:COUNT_W], count});
        cfg_write(CFG_RED_MASK, pick_mask());
        cfg_write(CFG_GREEN_MASK, pick_mask());
        cfg_write(CFG_BLUE_MASK, pick_mask());
        i_cfg_we <= 1'b0;
        phase_no++;
        sender_idle_pct = idle_plan[phase_no % 3];
    endtask

    // The search must never touch an entry that was never written, so every
    // indexed phase loads its searched prefix first.
    task automatic fill_palette(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            send_beat(OP_WRITE, i[7:0], pick_color());
            pace();
        end
    endtask

    // Random traffic in the current config.
    task automatic run_mix(input int n_beats);
        logic [1:0]  op;
        logic [7:0]  idx;
        logic [31:0] val;
        logic [31:0] e;
        int          roll;
        int          n;
        int          b;
        for (b = 0; b < n_beats; b++) begin
            n    = search_len();
            roll = $urandom_range(99);
            idx  = 8'($urandom_range(255));
            val  = $urandom();
            if (roll < 8) begin
                op  = OP_WRITE;
                val = pick_color();
            end else if (roll < 12) begin
                op = OP_NONE;
            end else if (roll < 56) begin
                op = OP_REALIZE;
                if (cur_type == PT_INDEXED && n > 0) begin
                    e    = palette_mirror[$urandom_range(n - 1)];
                    roll = $urandom_range(99);
                    // exact hit (top byte is ignored), near miss, or anything
                    if (roll < 45)
                        val = {val[31:24], e[23:0]};
                    else if (roll < 65)
                        val = e ^ (32'($urandom_range(1, 3)) << (8 * $urandom_range(2)));
                    else
                        val = pick_color();
                end else if ($urandom_range(9) == 0) begin
                    val = $urandom_range(1) ? '1 : '0;
                end
            end else begin
                op = OP_UNREALIZE;
                if (cur_type == PT_INDEXED && $urandom_range(99) < 60)
                    val = $urandom_range(n + 2);
                else if ($urandom_range(9) == 0)
                    val = $urandom_range(1) ? '1 : '0;
            end
            send_beat(op, idx, val);
            pace();
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // reset config is RGB passthrough; also the unused op
    task automatic test_reset_defaults();
        drain();
        send_beat(OP_REALIZE, 8'h00, 32'h0000_0000);
        send_beat(OP_REALIZE, 8'hFF, 32'hFFFF_FFFF);
        send_beat(OP_UNREALIZE, 8'h5A, 32'h1234_5678);
        send_beat(OP_NONE, 8'hA5, 32'hDEAD_BEEF);
    endtask

    // bitfields on the reset masks (565) with the reset count of three
    task automatic test_bitfields_reset_masks();
        drain();
        cfg_write(CFG_PALETTE_TYPE, 32'(PT_BITFIELDS));
        i_cfg_we <= 1'b0;
        send_beat(OP_REALIZE, 8'h00, 32'hFFFF_FFFF);
        send_beat(OP_REALIZE, 8'h00, 32'h0080_4020);
        send_beat(OP_UNREALIZE, 8'h00, 32'h0000_FFFF);
        send_beat(OP_UNREALIZE, 8'h00, 32'h0000_0841);
    endtask

    task automatic test_bgr_swap();
        drain();
        cfg_write(CFG_PALETTE_TYPE, 32'(PT_BGR));
        i_cfg_we <= 1'b0;
        send_beat(OP_REALIZE, 8'h00, 32'h1122_3344);
        send_beat(OP_UNREALIZE, 8'h00, 32'hAABB_CCDD);
    endtask

    // Four entries: 0 and 1 tie for 080808, entry 2 duplicates entry 1.
    task automatic test_indexed_search();
        drain();
        cfg_write(CFG_PALETTE_TYPE, 32'(PT_INDEXED));
        cfg_write(CFG_ENTRY_COUNT, 32'd4);
        i_cfg_we <= 1'b0;
        send_beat(OP_WRITE, 8'd0, 32'h0000_0000);
        send_beat(OP_WRITE, 8'd1, 32'h0010_1010);
        send_beat(OP_WRITE, 8'd2, 32'h0010_1010);
        send_beat(OP_WRITE, 8'd3, 32'hFFFF_FFFF);
        send_beat(OP_WRITE, 8'd255, 32'h00C0_FFEE);
        send_beat(OP_REALIZE, 8'd0, 32'h0008_0808);    // three-way tie, last wins
        send_beat(OP_REALIZE, 8'd0, 32'h0010_1010);    // exact match stops at 1
        send_beat(OP_REALIZE, 8'd0, 32'hFF00_0000);    // top byte not compared
        send_beat(OP_UNREALIZE, 8'd0, 32'd3);
        send_beat(OP_UNREALIZE, 8'd0, 32'd4);          // past entry_count
        send_beat(OP_UNREALIZE, 8'd0, 32'hFFFF_FFFF);
    endtask

    // empty search, then full-width and zero masks (plus a dead config index)
    task automatic test_empty_and_full_mask();
        drain();
        cfg_write(CFG_ENTRY_COUNT, 32'd0);
        i_cfg_we <= 1'b0;
        send_beat(OP_REALIZE, 8'd0, 32'h0012_3456);
        send_beat(OP_UNREALIZE, 8'd0, 32'd0);
        drain();
        cfg_write(CFG_PALETTE_TYPE, 32'(PT_BITFIELDS));
        cfg_write(CFG_ENTRY_COUNT, 32'd3);
        cfg_write(CFG_RED_MASK, 32'hFFFF_FFFF);
        cfg_write(CFG_GREEN_MASK, 32'h0000_0000);
        cfg_write(CFG_BLUE_MASK, 32'h00FF_0000);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        send_beat(OP_REALIZE, 8'd0, 32'h00CD_EFAB);
        send_beat(OP_UNREALIZE, 8'd0, 32'h8000_0000);
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------

    task automatic test_random_indexed();
        int ph;
        int cnt;
        for (ph = 0; ph < 4; ph++) begin
            cnt = (ph == 0) ? 1 : $urandom_range(2, 24);
            load_config(PT_INDEXED, COUNT_W'(cnt));
            fill_palette(cnt);
            run_mix(22);
        end
    endtask

    // whole table searched: few beats, each scanning up to all 256 entries
    task automatic test_full_table_search();
        load_config(PT_INDEXED, COUNT_W'(PALETTE_DEPTH));
        fill_palette(PALETTE_DEPTH);
        run_mix(14);
    endtask

    // mask counts 0..3 and one larger count that clamps to three
    task automatic test_random_bitfields();
        int ph;
        for (ph = 0; ph < 5; ph++) begin
            load_config(PT_BITFIELDS,
                        COUNT_W'((ph < 4) ? ph : $urandom_range(4, 256)));
            run_mix(20);
        end
    endtask

    task automatic test_random_swap_pass();
        load_config(PT_BGR, COUNT_W'($urandom_range(256)));
        run_mix(20);
        load_config(PT_RGB, COUNT_W'($urandom_range(256)));
        run_mix(20);
    endtask

    // ------------------------------------------------------------------
    // Result checker: a strobe cannot be held off, so every strobed cycle
    // is a beat taken at the closing edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (color_due.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h",
                         $time, o_result_color);
                fail_count++;
            end else begin
                want = color_due.pop_front();
                checked_count++;
                if (o_result_color !== want) begin
                    $display("%0t: result_color mismatch: expected %h, actual %h",
                             $time, want, o_result_color);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any accepted command or result beat restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, color_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cur_type    = PALETTE_TYPE_RST;
        cur_count   = ENTRY_COUNT_RST;
        cur_mask[0] = RED_MASK_RST;
        cur_mask[1] = GREEN_MASK_RST;
        cur_mask[2] = BLUE_MASK_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_bitfields_reset_masks();
        test_bgr_swap();
        test_indexed_search();
        test_empty_and_full_mask();
        test_random_indexed();
        test_full_table_search();
        test_random_bitfields();
        test_random_swap_pass();
        drain();

        $display("Covered %0d palette writes, %0d realize, %0d unrealize, %0d dead ops",
                 n_writes, n_realize, n_unrealize, n_dead_ops);
        $display("over all palette types, counts 0..256 and mask extremes; %0d results checked",
                 checked_count);
        if (fail_count == 0 && color_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
